FILE: hw/rtl/dmeu_pkg.sv
// Shared types, constants and helpers for the dynamic MIS edge update core.
package dmeu_pkg;

	localparam int NODES      = 64;
	localparam int ADDR_W     = $clog2(NODES);
	localparam int NODE_W     = 6;
	localparam int CNT_W      = 7;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	typedef logic [NODES-1:0]  row_t;
	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_SET    = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DROP,
		ST_ROW,
		ST_SCAN,
		ST_NB,
		ST_DEL_CHK,
		ST_RD_A,
		ST_WR_A,
		ST_RD_B,
		ST_WR_B,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic  rd_en;
		node_t rd_addr;
		logic  wr_en;
		node_t wr_addr;
		row_t  wr_data;
	} ram_req_t;

	// push: report a membership change; finish: close the item with last set
	typedef struct packed {
		logic  push;
		logic  finish;
		logic  ignored;
		node_t node;
		logic  member;
	} res_req_t;

	function automatic row_t bit_of(input node_t n);
		bit_of = row_t'(1) << n;
	endfunction

endpackage

FILE: hw/rtl/dynamic_mis_edge_update_core.sv
// Top level of the dynamic MIS edge update core.
//
// Input items arrive on the s_ channel: s_tuser carries the command (load edge, set
// membership, insert edge with update, delete edge with update) and s_tdata the
// endpoints and membership bit. Every item produces one or more results on the m_
// channel; each membership change is one transfer, and m_tlast marks the final
// transfer of the item (a bare completion or an ignored flag when nothing changed).
// cfg_data sets the node count; write it only while the core is idle.
// One item is worked at a time. A plain edge load or a delete is bound by four
// read/modify/write steps on the adjacency row store. An insert that drops a member
// scans that node's row one bit per cycle while no result is held up, plus one extra
// row read per non-member neighbor.
// Reset empties the graph at once (per-row valid bits, no clearing pass), clears
// membership and sets the node count to NODES. Results wait in an output register
// while the receiver stalls; the next item is taken meanwhile and the core holds
// only when it must hand over another result.
module dynamic_mis_edge_update_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dmeu_pkg::IN_DATA_W-1:0]     s_tdata,  // node_a[5:0], node_b[11:6], member_value[12]
	input  logic [1:0]                         s_tuser,  // cmd[1:0]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dmeu_pkg::OUT_DATA_W-1:0]    m_tdata,  // node[5:0], new_member[6]
	output logic [1:0]                         m_tuser,  // changed[0], ignored[1]
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dmeu_pkg::CNT_W-1:0]         cfg_data  // node_count
);
	import dmeu_pkg::*;

	ram_req_t ram_req;
	row_t     ram_rdata;
	res_req_t res_req;
	logic     res_ready;

	dmeu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_req   (res_req),
		.res_ready (res_ready)
	);

	dmeu_adj_ram u_adj_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (ram_rdata)
	);

	dmeu_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (res_req),
		.ready    (res_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: hw/rtl/dmeu_adj_ram.sv
// Adjacency row store: one row per node, synchronous read, per-row valid bits.
module dmeu_adj_ram (
	input  logic              clk,
	input  logic              arst_n,
	input  dmeu_pkg::ram_req_t req,
	output dmeu_pkg::row_t    rd_data
);
	import dmeu_pkg::*;

	row_t             mem [NODES];
	logic [NODES-1:0] valid_q;
	row_t             rdata_s1;
	logic             rvalid_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_s1 <= mem[req.rd_addr[ADDR_W-1:0]];
		end
	end

	// a row never written since reset reads as an empty row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr[ADDR_W-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_s1 <= valid_q[req.rd_addr[ADDR_W-1:0]];
			end
		end
	end

	assign rd_data = rvalid_s1 ? rdata_s1 : '0;

endmodule

FILE: hw/rtl/dmeu_result.sv
// Result staging: holds the latest change until the next one or the item end tags it.
module dmeu_result (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dmeu_pkg::res_req_t                 req,
	output logic                               ready,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dmeu_pkg::OUT_DATA_W-1:0]    m_tdata,  // node[5:0], new_member[6], zero[7]
	output logic [1:0]                         m_tuser,  // changed[0], ignored[1]
	output logic                               m_tlast
);
	import dmeu_pkg::*;

	logic  m_tvalid_q;
	logic  pend_valid_q;
	node_t pend_node_q;
	logic  pend_mem_q;
	node_t out_node_q;
	logic  out_mem_q;
	logic  out_chg_q;
	logic  out_ign_q;
	logic  out_last_q;
	logic  out_free;
	logic  load_out;

	assign out_free = !m_tvalid_q || m_tready;
	assign ready    = req.finish ? out_free : (!pend_valid_q || out_free);
	assign load_out = ready && ((req.push && pend_valid_q) || req.finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (req.push && ready) begin
				pend_valid_q <= 1'b1;
			end else if (req.finish && ready) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.push && ready) begin
			pend_node_q <= req.node;
			pend_mem_q  <= req.member;
		end
		if (load_out) begin
			if (pend_valid_q) begin
				out_node_q <= pend_node_q;
				out_mem_q  <= pend_mem_q;
				out_chg_q  <= 1'b1;
				out_ign_q  <= 1'b0;
			end else begin
				out_node_q <= '0;
				out_mem_q  <= 1'b0;
				out_chg_q  <= 1'b0;
				out_ign_q  <= req.ignored;
			end
			out_last_q <= req.finish;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_mem_q, out_node_q};
	assign m_tuser  = {out_ign_q, out_chg_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: hw/rtl/dmeu_ctrl.sv
// Update sequencer: decodes items, walks neighbor rows and keeps the membership row.
module dmeu_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [dmeu_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  dmeu_pkg::cnt_t                   cfg_data,
	output dmeu_pkg::ram_req_t               ram_req,
	input  dmeu_pkg::row_t                   ram_rdata,
	output dmeu_pkg::res_req_t               res_req,
	input  logic                             res_ready
);
	import dmeu_pkg::*;

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	node_t             a_q, b_q;
	logic              mv_q;
	row_t              mem_q, mem_d;
	row_t              row_q, row_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic              ign_q, ign_d;
	cnt_t              cnt_q, cnt_new;
	row_t              live_q, live_new;

	row_t  a_bit, b_bit;
	logic  ma, mb, oob, idx_last;
	node_t rem, cand, excl;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign cnt_new = (cfg_data > cnt_t'(NODES)) ? cnt_t'(NODES) : cfg_data;
	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			live_new[i] = cnt_t'(i) < cnt_new;
		end
	end

	assign a_bit    = bit_of(a_q);
	assign b_bit    = bit_of(b_q);
	assign ma       = |(mem_q & a_bit);
	assign mb       = |(mem_q & b_bit);
	assign oob      = ({1'b0, a_q} >= cnt_q) || ((cmd_q != CMD_SET) && ({1'b0, b_q} >= cnt_q));
	assign rem      = (a_q < b_q) ? a_q : b_q;
	assign cand     = ma ? b_q : a_q;
	assign excl     = ma ? a_q : b_q;
	assign idx_last = (idx_q == ADDR_W'(NODES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mem_q   <= '0;
			ign_q   <= 1'b0;
			cnt_q   <= cnt_t'(NODES);
			live_q  <= '1;
		end else begin
			state_q <= state_d;
			mem_q   <= mem_d;
			ign_q   <= ign_d;
			if (cfg_valid && cfg_ready) begin
				cnt_q  <= cnt_new;
				live_q <= live_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmd_t'(s_tuser);
			a_q   <= s_tdata[NODE_W-1:0];
			b_q   <= s_tdata[2*NODE_W-1:NODE_W];
			mv_q  <= s_tdata[2*NODE_W];
		end
		row_q <= row_d;
		idx_q <= idx_d;
	end

	always_comb begin
		state_d = state_q;
		mem_d   = mem_q;
		row_d   = row_q;
		idx_d   = idx_q;
		ign_d   = ign_q;
		ram_req = '0;
		res_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ign_d   = 1'b0;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (oob) begin
					ign_d   = 1'b1;
					state_d = ST_FINISH;
				end else begin
					unique case (cmd_q)
						CMD_LOAD: state_d = ST_RD_A;
						CMD_SET: begin
							mem_d   = mv_q ? (mem_q | a_bit) : (mem_q & ~a_bit);
							state_d = ST_FINISH;
						end
						CMD_INSERT: state_d = (ma && mb) ? ST_DROP : ST_RD_A;
						CMD_DELETE: begin
							if (ma != mb) begin
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = cand;
								state_d         = ST_DEL_CHK;
							end else begin
								state_d = ST_RD_A;
							end
						end
					endcase
				end
			end
			ST_DROP: begin
				res_req.push   = 1'b1;
				res_req.node   = rem;
				res_req.member = 1'b0;
				if (res_ready) begin
					mem_d           = mem_q & ~bit_of(rem);
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = rem;
					state_d         = ST_ROW;
				end
			end
			ST_ROW: begin
				row_d   = ram_rdata & live_q;
				idx_d   = '0;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (row_q[idx_q] && !mem_q[idx_q]) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = node_t'(idx_q);
					state_d         = ST_NB;
				end else if (idx_last) begin
					state_d = ST_RD_A;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_NB: begin
				// join only if no live neighbor is a member right now
				if ((ram_rdata & live_q & mem_q) == '0) begin
					res_req.push   = 1'b1;
					res_req.node   = node_t'(idx_q);
					res_req.member = 1'b1;
				end
				if (!res_req.push || res_ready) begin
					if (res_req.push) begin
						mem_d = mem_q | bit_of(node_t'(idx_q));
					end
					if (idx_last) begin
						state_d = ST_RD_A;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_DEL_CHK: begin
				if ((ram_rdata & live_q & mem_q & ~bit_of(excl)) == '0) begin
					res_req.push   = 1'b1;
					res_req.node   = cand;
					res_req.member = 1'b1;
					if (res_ready) begin
						mem_d   = mem_q | bit_of(cand);
						state_d = ST_RD_A;
					end
				end else begin
					state_d = ST_RD_A;
				end
			end
			ST_RD_A: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = a_q;
				state_d         = ST_WR_A;
			end
			ST_WR_A: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = a_q;
				ram_req.wr_data = (cmd_q == CMD_DELETE) ? (ram_rdata & ~b_bit)
				                                        : (ram_rdata | b_bit);
				state_d         = ST_RD_B;
			end
			ST_RD_B: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = b_q;
				state_d         = ST_WR_B;
			end
			ST_WR_B: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = b_q;
				ram_req.wr_data = (cmd_q == CMD_DELETE) ? (ram_rdata & ~a_bit)
				                                        : (ram_rdata | a_bit);
				state_d         = ST_FINISH;
			end
			ST_FINISH: begin
				res_req.finish  = 1'b1;
				res_req.ignored = ign_q;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DISPATCH))
		else $error("accepted item did not enter dispatch");

	a_idle_mem_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> $stable(mem_q))
		else $error("membership changed while idle");

	a_oob_mem_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DISPATCH && oob) |=> $stable(mem_q))
		else $error("out of range item changed membership");

	a_wr_endpoint: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.wr_en |-> (ram_req.wr_addr == a_q || ram_req.wr_addr == b_q))
		else $error("row write away from the item endpoints");

	a_scan_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NB) |-> (row_q[idx_q] && !mem_q[idx_q]))
		else $error("neighbor check on a node that is not a non-member neighbor");

endmodule
